// ===== hw/rtl/udwlb_pkg.sv =====
// ----------------------------------------------------------------------------
// udwlb_pkg
// Shared types and constants of the UTF-8 display width line breaker.
// ----------------------------------------------------------------------------
package udwlb_pkg;

   localparam int unsigned MaxCutsDefault   = 256;
   localparam logic [7:0]  LineWidthReset   = 8'd50;
   localparam int unsigned QueueDepth       = 4;
   localparam int unsigned QueuePtrW        = $clog2(QueueDepth);
   localparam int unsigned QueueCountW      = $clog2(QueueDepth + 1);

   localparam logic [7:0]  LineFeed         = 8'h0A;
   localparam logic [7:0]  CarriageReturn   = 8'h0D;

   localparam logic        RecordCut        = 1'b0;
   localparam logic        RecordSummary    = 1'b1;

   localparam logic [8:0]  FullLinesMax     = 9'd511;
   localparam logic [15:0] CharTotalMax     = 16'hFFFF;

   typedef struct packed {
      logic        record_type;
      logic [15:0] cut_position;
      logic [8:0]  full_lines;
      logic [7:0]  tail_width;
      logic        run_last;
   } rec_type;

   typedef struct packed {
      logic push_first;
      logic push_second;
   } push_type;

endpackage

// ===== hw/rtl/udwlb_step.sv =====
// ----------------------------------------------------------------------------
// udwlb_step
// Per-byte update of the line state and building of cut and summary records.
// ----------------------------------------------------------------------------
module udwlb_step import udwlb_pkg::*; #(
   parameter int unsigned MAX_CUTS = MaxCutsDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  logic [7:0] byte_in,
   input  logic       end_of_text,
   input  logic [7:0] line_width,
   output push_type   push,
   output rec_type    rec_first,
   output rec_type    rec_second
);

   localparam int unsigned CutsW = $clog2(MAX_CUTS + 1);

   logic [1:0]       skip_left_ff, skip_left_in;
   logic [7:0]       width_used_ff, width_used_in;
   logic [15:0]      char_total_ff, char_total_in;
   logic [CutsW-1:0] cuts_made_ff, cuts_made_in;

   logic [7:0]       char_width;
   logic [1:0]       char_skip;
   logic [8:0]       width_sum;
   logic [15:0]      pos;
   logic             cut_report;
   logic [CutsW+8:0] cuts_ext;
   logic [8:0]       lines_shown;
   rec_type          cut_rec;
   rec_type          sum_rec;

   always_comb begin
      skip_left_in  = skip_left_ff;
      width_used_in = width_used_ff;
      char_total_in = char_total_ff;
      cuts_made_in  = cuts_made_ff;
      cut_report    = 1'b0;
      pos           = char_total_ff;
      char_width    = 8'd2;
      char_skip     = 2'd3;
      width_sum     = 9'd0;
      if (byte_in inside {[8'h00:8'h7F]}) begin
         char_width = 8'd1;
         char_skip  = 2'd0;
      end else if (byte_in inside {[8'hC0:8'hDF]}) begin
         char_skip  = 2'd1;
      end else if (byte_in inside {[8'hE0:8'hEF]}) begin
         char_skip  = 2'd2;
      end
      if (skip_left_ff != 2'd0) begin
         skip_left_in = skip_left_ff - 2'd1;
      end else begin
         if (char_total_ff != CharTotalMax) begin
            char_total_in = char_total_ff + 16'd1;
         end
         pos = char_total_in;
         if (byte_in inside {LineFeed, CarriageReturn}) begin
            width_used_in = 8'd0;
         end else begin
            skip_left_in = char_skip;
            width_sum    = {1'b0, width_used_ff} + {1'b0, char_width};
            if (width_sum == {1'b0, line_width}) begin
               width_used_in = 8'd0;
               cut_report    = cuts_made_ff < CutsW'(MAX_CUTS);
            end else if (width_sum > {1'b0, line_width}) begin
               width_used_in = 8'd2;
               pos           = char_total_in - 16'd1;
               cut_report    = cuts_made_ff < CutsW'(MAX_CUTS);
            end else begin
               width_used_in = width_sum[7:0];
            end
            if (cut_report) begin
               cuts_made_in = cuts_made_ff + CutsW'(1);
            end
         end
      end
   end

   assign cuts_ext    = (CutsW + 9)'(cuts_made_in);
   assign lines_shown = (cuts_ext > (CutsW + 9)'(FullLinesMax)) ? FullLinesMax
                                                                 : cuts_ext[8:0];

   always_comb begin
      cut_rec.record_type  = RecordCut;
      cut_rec.cut_position = pos;
      cut_rec.full_lines   = lines_shown;
      cut_rec.tail_width   = width_used_in;
      cut_rec.run_last     = !end_of_text;
      sum_rec.record_type  = RecordSummary;
      sum_rec.cut_position = char_total_in;
      sum_rec.full_lines   = lines_shown;
      sum_rec.tail_width   = width_used_in;
      sum_rec.run_last     = 1'b1;
      rec_first            = cut_report ? cut_rec : sum_rec;
      rec_second           = sum_rec;
      push.push_first      = fire && (cut_report || end_of_text);
      push.push_second     = fire && cut_report && end_of_text;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_left_ff  <= 2'd0;
         width_used_ff <= 8'd0;
         char_total_ff <= 16'd0;
         cuts_made_ff  <= '0;
      end else if (fire) begin
         if (end_of_text) begin
            skip_left_ff  <= 2'd0;
            width_used_ff <= 8'd0;
            char_total_ff <= 16'd0;
            cuts_made_ff  <= '0;
         end else begin
            skip_left_ff  <= skip_left_in;
            width_used_ff <= width_used_in;
            char_total_ff <= char_total_in;
            cuts_made_ff  <= cuts_made_in;
         end
      end
   end

endmodule

// ===== hw/rtl/udwlb_queue.sv =====
// ----------------------------------------------------------------------------
// udwlb_queue
// Result queue taking up to two records per cycle and handing out one.
// ----------------------------------------------------------------------------
module udwlb_queue import udwlb_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  push_type               push,
   input  rec_type                rec_first,
   input  rec_type                rec_second,
   input  logic                   pop,
   output rec_type                rec_out,
   output logic [QueueCountW-1:0] count
);

   rec_type                entry_ff [QueueDepth];
   logic [QueuePtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0]   rd_ptr_ff;
   logic [QueueCountW-1:0] count_ff, count_in;
   logic [QueuePtrW-1:0]   wr_next;

   assign wr_next = wr_ptr_ff + QueuePtrW'(1);
   assign rec_out = entry_ff[rd_ptr_ff];
   assign count   = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QueuePtrW'({1'b0, push.push_first} + {1'b0, push.push_second});
      count_in  = count_ff + QueueCountW'(push.push_first) + QueueCountW'(push.push_second)
                  - QueueCountW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.push_first) begin
         entry_ff[wr_ptr_ff] <= rec_first;
      end
      if (push.push_second) begin
         entry_ff[wr_next] <= rec_second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QueuePtrW'(1);
         end
      end
   end

endmodule

// ===== hw/rtl/utf8_display_width_line_breaker_core.sv =====
// Path: a transferred byte is held in the input register, then its records are written into the result queue.
// Throughput: one byte per cycle while the result queue has room; a byte giving a cut and a
// summary puts two records into the queue, which hands out a single record per pop.
// Reset: synchronous, clears line state and queue; line_width returns to 50.
// ----------------------------------------------------------------------------
// utf8_display_width_line_breaker_core
// Splits a UTF-8 byte stream into lines of a set display width.
// ----------------------------------------------------------------------------
module utf8_display_width_line_breaker_core import udwlb_pkg::*; #(
   parameter int unsigned MAX_CUTS = MaxCutsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_byte_in,
   input  logic        req_end_of_text,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_record_type,
   output logic [15:0] rsp_cut_position,
   output logic [8:0]  rsp_full_lines,
   output logic [7:0]  rsp_tail_width,
   output logic        rsp_run_last,
   input  logic        csr_write_enable,
   input  logic [7:0]  csr_write_data
);

   logic                   in_valid_ff, in_valid_in;
   logic [7:0]             byte_ff;
   logic                   eot_ff;
   logic [7:0]             line_width_ff;
   logic                   fire;
   logic                   take;
   logic [QueueCountW-1:0] count;
   push_type               push;
   rec_type                rec_first;
   rec_type                rec_second;
   rec_type                rec_out;

   assign fire      = in_valid_ff && (count < QueueCountW'(QueueDepth - 1));
   assign req_stall = in_valid_ff && !fire;
   assign take      = req_valid && !req_stall;
   assign rsp_valid = count != '0;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         line_width_ff <= LineWidthReset;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_write_enable) begin
            line_width_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff <= req_byte_in;
         eot_ff  <= req_end_of_text;
      end
   end

   udwlb_step #(
      .MAX_CUTS(MAX_CUTS)
   ) u_step (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .byte_in    (byte_ff),
      .end_of_text(eot_ff),
      .line_width (line_width_ff),
      .push       (push),
      .rec_first  (rec_first),
      .rec_second (rec_second)
   );

   udwlb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .rec_first (rec_first),
      .rec_second(rec_second),
      .pop       (rsp_valid && !rsp_stall),
      .rec_out   (rec_out),
      .count     (count)
   );

   assign rsp_record_type  = rec_out.record_type;
   assign rsp_cut_position = rec_out.cut_position;
   assign rsp_full_lines   = rec_out.full_lines;
   assign rsp_tail_width   = rec_out.tail_width;
   assign rsp_run_last     = rec_out.run_last;

endmodule

// ===== sim/utf8_display_width_line_breaker_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_display_width_line_breaker_core_tb
// Self-checking bench for the UTF-8 line breaker. A software copy of the line
// state predicts the cut and summary records of every byte transfer; a
// checker compares each result transfer with the oldest prediction. Directed
// texts, tiny widths, the cut limit and random texts run with bursty sending
// and random result stalls, save the long cut-limit text and one random phase.
// ----------------------------------------------------------------------------
module utf8_display_width_line_breaker_core_tb;
   import udwlb_pkg::*;

   localparam int unsigned MAX_CUTS   = MaxCutsDefault;
   localparam int unsigned SETTLE_CYC = 6;

   logic        clock;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_stall;
   logic [7:0]  req_byte_in      = 8'h00;
   logic        req_end_of_text  = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall        = 1'b0;
   logic        rsp_record_type;
   logic [15:0] rsp_cut_position;
   logic [8:0]  rsp_full_lines;
   logic [7:0]  rsp_tail_width;
   logic        rsp_run_last;
   logic        csr_write_enable = 1'b0;
   logic [7:0]  csr_write_data   = 8'h00;

   // predicted line state
   logic [1:0]  brk_skip       = '0;
   logic [7:0]  brk_width      = '0;
   logic [15:0] brk_chars      = '0;
   logic [8:0]  brk_cuts       = '0;
   logic [7:0]  brk_line_width = LineWidthReset;

   rec_type     pending_records[$];
   rec_type     want_rec;
   rec_type     got_rec;

   int unsigned bytes_sent     = 0;
   int unsigned records_seen   = 0;
   int unsigned error_count    = 0;
   int unsigned width_settings = 0;
   int unsigned burst_left     = 0;
   int unsigned tx_gap_max     = 3;
   int unsigned rx_stall_pct   = 25;
   int unsigned stall_hold     = 0;

   utf8_display_width_line_breaker_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_byte_in      (req_byte_in),
      .req_end_of_text  (req_end_of_text),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_record_type  (rsp_record_type),
      .rsp_cut_position (rsp_cut_position),
      .rsp_full_lines   (rsp_full_lines),
      .rsp_tail_width   (rsp_tail_width),
      .rsp_run_last     (rsp_run_last),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #80_000_000;
      $display("[utf8_display_width_line_breaker_core] ERROR");
      $finish;
   end

   // result stall pattern
   always @(posedge clock) begin
      if (stall_hold != 0) begin
         stall_hold <= stall_hold - 1;
      end else begin
         rsp_stall  <= ($urandom_range(0, 99) < rx_stall_pct);
         stall_hold <= $urandom_range(0, 6);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         got_rec = '{rsp_record_type, rsp_cut_position, rsp_full_lines,
                     rsp_tail_width, rsp_run_last};
         records_seen++;
         if (pending_records.size() == 0) begin
            $display("%0t: unexpected result: type=%0d pos=%0d lines=%0d tail=%0d last=%0d",
                     $time, got_rec.record_type, got_rec.cut_position,
                     got_rec.full_lines, got_rec.tail_width, got_rec.run_last);
            error_count++;
         end else begin
            want_rec = pending_records.pop_front();
            if (got_rec !== want_rec) begin
               $display("%0t: mismatch: expected type=%0d pos=%0d lines=%0d tail=%0d last=%0d",
                        $time, want_rec.record_type, want_rec.cut_position,
                        want_rec.full_lines, want_rec.tail_width, want_rec.run_last);
               $display("%0t:           actual   type=%0d pos=%0d lines=%0d tail=%0d last=%0d",
                        $time, got_rec.record_type, got_rec.cut_position,
                        got_rec.full_lines, got_rec.tail_width, got_rec.run_last);
               error_count++;
            end
         end
      end
   end

   task automatic break_byte(input logic [7:0] b, input logic eot);
      rec_type     recs[$];
      rec_type     r;
      int unsigned w;
      int unsigned sum;
      int unsigned pos;
      bit          cut;
      if (brk_skip != 0) begin
         brk_skip--;
      end else begin
         if (brk_chars != CharTotalMax) brk_chars++;
         if (b == LineFeed || b == CarriageReturn) begin
            brk_width = '0;
         end else begin
            w = b[7] ? 2 : 1;
            if (!b[7])                 brk_skip = 2'd0;
            else if (b[7:5] == 3'b110)  brk_skip = 2'd1;
            else if (b[7:4] == 4'b1110) brk_skip = 2'd2;
            else                        brk_skip = 2'd3;
            sum = brk_width + w;
            pos = brk_chars;
            cut = 1'b0;
            if (sum == brk_line_width) begin
               cut       = 1'b1;
               brk_width = '0;
            end else if (sum > brk_line_width) begin
               cut       = 1'b1;
               pos       = brk_chars - 1;
               brk_width = 8'd2;
            end else begin
               brk_width = sum[7:0];
            end
            if (cut && brk_cuts < MAX_CUTS) begin
               brk_cuts++;
               r = '{RecordCut, pos[15:0], brk_cuts, brk_width, 1'b0};
               recs.push_back(r);
            end
         end
      end
      if (eot) begin
         r = '{RecordSummary, brk_chars, brk_cuts, brk_width, 1'b0};
         recs.push_back(r);
         brk_skip  = '0;
         brk_width = '0;
         brk_chars = '0;
         brk_cuts  = '0;
      end
      if (recs.size() != 0) recs[recs.size() - 1].run_last = 1'b1;
      foreach (recs[i]) pending_records.push_back(recs[i]);
   endtask

   task automatic send_byte(input logic [7:0] b, input logic eot);
      int unsigned gap;
      req_valid       <= 1'b1;
      req_byte_in     <= b;
      req_end_of_text <= eot;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      break_byte(b, eot);
      bytes_sent++;
      if (burst_left != 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 31);
         gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic wait_drained;
      req_valid <= 1'b0;
      while (pending_records.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic write_line_width(input logic [7:0] w);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_write_data   <= w;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      brk_line_width = w;
      width_settings++;
   endtask

   task automatic send_text(input logic [7:0] text_q[$]);
      foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
   endtask

   task automatic send_random_text(input int unsigned len, input bit long_line);
      logic [7:0]  text_q[$];
      logic [7:0]  lead;
      int unsigned sel;
      int unsigned n_cont;
      int unsigned drop;
      n_cont = 0;
      while (text_q.size() < len) begin
         sel    = $urandom_range(0, 99);
         n_cont = 0;
         if (sel < 10 && !long_line) begin
            lead = 8'($urandom_range(0, 255));
         end else if (sel < 45) begin
            lead = 8'(long_line ? $urandom_range(8'h20, 8'h7E) : $urandom_range(0, 127));
         end else if (sel < 55 && !long_line) begin
            lead = $urandom_range(0, 1) ? LineFeed : CarriageReturn;
         end else if (sel < 70) begin
            lead   = 8'hC0 | 8'($urandom_range(0, 31));
            n_cont = 1;
         end else if (sel < 85) begin
            lead   = 8'hE0 | 8'($urandom_range(0, 15));
            n_cont = 2;
         end else begin
            lead   = 8'hF0 | 8'($urandom_range(0, 7));
            n_cont = 3;
         end
         text_q.push_back(lead);
         repeat (n_cont) text_q.push_back(8'h80 | 8'($urandom_range(0, 63)));
      end
      // cut the last character short now and then
      if (n_cont != 0 && $urandom_range(0, 9) == 0) begin
         drop = $urandom_range(1, n_cont);
         repeat (drop) void'(text_q.pop_back());
      end
      send_text(text_q);
   endtask

   task automatic test_directed;
      send_text('{8'h00, 8'h7F, LineFeed, CarriageReturn});
      write_line_width(8'd5);
      // exact fit, newlines swallowed as continuations, odd leads, overflow
      // cut, then a text that ends inside a character
      send_text('{8'h41, 8'hC2, 8'h80, 8'hE2, LineFeed, CarriageReturn,
                  8'hF0, 8'h9F, 8'h98, 8'h80, 8'hBF, 8'h80, 8'h80, 8'h80,
                  8'hFF, 8'h80, 8'h31});
      // cut and summary from one byte
      send_text('{8'h41, 8'h41, 8'h41, 8'h41, 8'h41});
      send_text('{8'h80});
   endtask

   task automatic test_tiny_widths;
      write_line_width(8'd0);
      repeat (3) send_random_text($urandom_range(1, 12), 1'b0);
      write_line_width(8'd1);
      repeat (3) send_random_text($urandom_range(1, 12), 1'b0);
   endtask

   task automatic test_cut_limit;
      logic [7:0] text_q[$];
      write_line_width(8'd2);
      tx_gap_max   = 0;
      rx_stall_pct = 0;
      repeat (530) text_q.push_back(8'h61);
      text_q.push_back(8'hF0);
      text_q.push_back(8'h90);
      text_q.push_back(8'h80);
      text_q.push_back(8'h80);
      send_text(text_q);
      tx_gap_max   = 2;
      rx_stall_pct = 40;
      send_text('{8'h61, 8'h62, 8'h63});
   endtask

   task automatic test_random_texts;
      int unsigned start;
      int unsigned len;
      bit          long_line;
      bit          drained;
      logic [7:0]  widths[6];
      int unsigned gaps[6];
      int unsigned stalls[6];
      widths = '{8'd2, 8'd255, 8'd50, 8'd0, 8'd0, 8'd3};
      widths[3] = 8'($urandom_range(3, 254));
      widths[4] = 8'($urandom_range(3, 254));
      gaps   = '{4, 0, 8, 2, 6, 3};
      stalls = '{30, 0, 60, 20, 45, 10};
      drained = 1'b0;
      for (int p = 0; p < 6; p++) begin
         write_line_width(widths[p]);
         tx_gap_max   = gaps[p];
         rx_stall_pct = stalls[p];
         start = bytes_sent;
         while (bytes_sent - start < 70) begin
            long_line = ($urandom_range(0, 11) == 0);
            len = long_line ? $urandom_range(100, 200) : $urandom_range(1, 40);
            send_random_text(len, long_line);
            // hold off until the block has caught up
            if (p == 2 && !drained && bytes_sent - start > 30) begin
               wait_drained();
               drained = 1'b1;
            end
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_tiny_widths();
      test_cut_limit();
      test_random_texts();
      wait_drained();
      $display("Checked %0d result transfers from %0d byte transfers over %0d width settings,",
               records_seen, bytes_sent, width_settings);
      $display("covering tiny widths, the cut limit and random texts.");
      if (error_count == 0 && pending_records.size() == 0) begin
         $display("[utf8_display_width_line_breaker_core] OK");
      end else begin
         $display("[utf8_display_width_line_breaker_core] ERROR");
      end
      $finish;
   end

endmodule
